// ===== hdl/gaze_vector_to_angles_assert.svh =====
`ifndef GAZE_VECTOR_TO_ANGLES_ASSERT_SVH
`define GAZE_VECTOR_TO_ANGLES_ASSERT_SVH

// implication checked in the same cycle
`define GVA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gaze_vector_to_angles assertion failed");

// implication checked in the next cycle
`define GVA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gaze_vector_to_angles assertion failed");

`endif

// ===== hdl/gva_pkg.sv =====
package gva_pkg;

   localparam int COORD_W   = 29;
   localparam int ANGLE_W   = 27;
   localparam int PROD_W    = 32;
   localparam int TABLE_LEN = 24;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic signed [PROD_W-1:0]  prod_type;

   typedef struct packed {
      logic zero;
      logic axis;
   } flags_type;

   typedef struct packed {
      flags_type flags;
      coord_type yk;
   } p1_side_type;

   typedef struct packed {
      flags_type flags;
      angle_type yaw;
   } p2_side_type;

   localparam prod_type  GAIN_Q14  = 32'sd26981;
   localparam angle_type DEG90     = 27'sd5898240;
   localparam angle_type ROUND_ADD = 27'sd256;
   localparam angle_type YAW_MIN   = -27'sd11520;
   localparam angle_type YAW_MAX   = 27'sd34560;
   localparam angle_type PITCH_MAX = 27'sd11520;

   localparam logic signed [16:0] YAW_ZERO_VEC   = 17'sd11520;
   localparam logic signed [14:0] PITCH_ZERO_VEC = 15'sd0;

   localparam angle_type ATAN_TABLE [0:TABLE_LEN-1] = '{
      27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
      27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
      27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
      27'sd917,     27'sd458,     27'sd229,    27'sd115,
      27'sd57,      27'sd29,      27'sd14,     27'sd7,
      27'sd4,       27'sd2,       27'sd1,      27'sd0
   };

endpackage

// ===== hdl/gva_req_if.sv =====
interface gva_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] vec_x;
   logic signed [15:0] vec_y;
   logic signed [15:0] vec_z;

   modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
   modport sink (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

// ===== hdl/gva_rsp_if.sv =====
interface gva_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] yaw_angle;
   logic signed [14:0] pitch_angle;
   logic               zero_vector;

   modport source (output valid, output yaw_angle, output pitch_angle, output zero_vector,
                   input ready);
   modport sink (input valid, input yaw_angle, input pitch_angle, input zero_vector,
                 output ready);
endinterface

// ===== hdl/gva_prep.sv =====
module gva_prep (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic signed [15:0]  vec_x,
   input  logic signed [15:0]  vec_y,
   input  logic signed [15:0]  vec_z,
   output logic                out_valid,
   output gva_pkg::coord_type  out_a,
   output gva_pkg::coord_type  out_b,
   output gva_pkg::angle_type  out_ang,
   output gva_pkg::p1_side_type out_side
);
   import gva_pkg::*;

   logic        valid_ff;
   coord_type   a_ff, b_ff, a_in, b_in;
   angle_type   ang_ff, ang_in;
   p1_side_type side_ff, side_in;
   coord_type   x_w, z_w;
   prod_type    y_prod;

   // coordinates widened by 8 fraction bits
   assign x_w    = coord_type'(vec_x) <<< 8;
   assign z_w    = coord_type'(vec_z) <<< 8;
   assign y_prod = prod_type'(vec_y) * GAIN_Q14;

   always_comb begin
      side_in.flags.zero = (vec_x == 16'sd0) && (vec_y == 16'sd0) && (vec_z == 16'sd0);
      side_in.flags.axis = (vec_x == 16'sd0) && (vec_z == 16'sd0);
      side_in.yk         = coord_type'(y_prod >>> 6);
      if (vec_x[15]) begin
         if (!vec_z[15]) begin
            a_in   = z_w;
            b_in   = -x_w;
            ang_in = DEG90;
         end else begin
            a_in   = -z_w;
            b_in   = x_w;
            ang_in = -DEG90;
         end
      end else begin
         a_in   = x_w;
         b_in   = z_w;
         ang_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         ang_ff  <= ang_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_ang   = ang_ff;
   assign out_side  = side_ff;
endmodule

// ===== hdl/gva_cordic.sv =====
module gva_cordic #(
   parameter int STAGES = 16,
   parameter int SIDE_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  gva_pkg::coord_type in_a,
   input  gva_pkg::coord_type in_b,
   input  gva_pkg::angle_type in_ang,
   input  logic [SIDE_W-1:0]  in_side,
   output logic               out_valid,
   output gva_pkg::coord_type out_a,
   output gva_pkg::angle_type out_ang,
   output logic [SIDE_W-1:0]  out_side
);
   import gva_pkg::*;

   logic              valid_ff [STAGES];
   coord_type         a_ff     [STAGES];
   coord_type         b_ff     [STAGES];
   angle_type         ang_ff   [STAGES];
   logic [SIDE_W-1:0] side_ff  [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic              valid_cur;
      coord_type         a_cur, b_cur, a_in, b_in;
      angle_type         ang_cur, ang_in;
      logic [SIDE_W-1:0] side_cur;

      if (i == 0) begin : g_first
         assign valid_cur = in_valid;
         assign a_cur     = in_a;
         assign b_cur     = in_b;
         assign ang_cur   = in_ang;
         assign side_cur  = in_side;
      end else begin : g_next
         assign valid_cur = valid_ff[i-1];
         assign a_cur     = a_ff[i-1];
         assign b_cur     = b_ff[i-1];
         assign ang_cur   = ang_ff[i-1];
         assign side_cur  = side_ff[i-1];
      end

      // turn toward the positive a axis
      always_comb begin
         if (!b_cur[COORD_W-1]) begin
            a_in   = a_cur + (b_cur >>> i);
            b_in   = b_cur - (a_cur >>> i);
            ang_in = ang_cur + ATAN_TABLE[i];
         end else begin
            a_in   = a_cur - (b_cur >>> i);
            b_in   = b_cur + (a_cur >>> i);
            ang_in = ang_cur - ATAN_TABLE[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            a_ff[i]    <= a_in;
            b_ff[i]    <= b_in;
            ang_ff[i]  <= ang_in;
            side_ff[i] <= side_cur;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_a     = a_ff[STAGES-1];
   assign out_ang   = ang_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];
endmodule

// ===== hdl/gva_finish.sv =====
module gva_finish (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  gva_pkg::angle_type   in_pitch,
   input  gva_pkg::p2_side_type in_side,
   output logic                 out_valid,
   output logic signed [16:0]   out_yaw,
   output logic signed [14:0]   out_pitch,
   output logic                 out_zero
);
   import gva_pkg::*;

   logic               valid_ff;
   logic signed [16:0] yaw_ff, yaw_in;
   logic signed [14:0] pitch_ff, pitch_in;
   logic               zero_ff;
   angle_type          yaw_raw, yaw_r, pitch_r;

   assign yaw_raw = in_side.flags.axis ? DEG90 : in_side.yaw + DEG90;
   assign yaw_r   = (yaw_raw + ROUND_ADD) >>> 9;
   assign pitch_r = (in_pitch + ROUND_ADD) >>> 9;

   always_comb begin
      if (in_side.flags.zero) begin
         yaw_in   = YAW_ZERO_VEC;
         pitch_in = PITCH_ZERO_VEC;
      end else begin
         if (yaw_r < YAW_MIN) begin
            yaw_in = YAW_MIN[16:0];
         end else if (yaw_r > YAW_MAX) begin
            yaw_in = YAW_MAX[16:0];
         end else begin
            yaw_in = yaw_r[16:0];
         end
         if (pitch_r < -PITCH_MAX) begin
            pitch_in = 15'(-PITCH_MAX);
         end else if (pitch_r > PITCH_MAX) begin
            pitch_in = PITCH_MAX[14:0];
         end else begin
            pitch_in = pitch_r[14:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         yaw_ff   <= yaw_in;
         pitch_ff <= pitch_in;
         zero_ff  <= in_side.flags.zero;
      end
   end

   assign out_valid = valid_ff;
   assign out_yaw   = yaw_ff;
   assign out_pitch = pitch_ff;
   assign out_zero  = zero_ff;
endmodule

// ===== hdl/gaze_vector_to_angles.sv =====
// Turns a 3-D direction vector into yaw (90 deg + atan2(z, x)) and pitch
// (asin(y / length)) in 1/128 degree, with a flag for the all-zero vector.
// One vector is taken every cycle while the response side is not stalled;
// each result passes through an input stage, the two unrolled CORDIC passes
// in series (one register per iteration) and the result register. While a
// result waits in the result register the whole pipeline holds, so no
// transaction is lost or repeated.
module gaze_vector_to_angles #(
   parameter int CORDIC_STAGES = 16
) (
   input logic     clock,
   input logic     reset,
   gva_req_if.sink   req_chan,
   gva_rsp_if.source rsp_chan
);
   import gva_pkg::*;

   logic         en;
   logic         p0_valid, p1_valid, p2_valid;
   coord_type    p0_a, p0_b, p1_len, p1_unused_b;
   angle_type    p0_ang, p1_ang, p2_ang;
   p1_side_type  p0_side, p1_side;
   p2_side_type  p2_in_side, p2_side;
   logic         rsp_held, rsp_zero_ok, rsp_pitch_ok, rsp_yaw_ok;
   logic [2:0]   pipe_valids;

   assign en             = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = en;
   assign p1_unused_b    = p1_side.yk;

   gva_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_chan.valid),
      .vec_x    (req_chan.vec_x),
      .vec_y    (req_chan.vec_y),
      .vec_z    (req_chan.vec_z),
      .out_valid(p0_valid),
      .out_a    (p0_a),
      .out_b    (p0_b),
      .out_ang  (p0_ang),
      .out_side (p0_side)
   );

   // yaw pass over (x, z)
   gva_cordic #(
      .STAGES(CORDIC_STAGES),
      .SIDE_W($bits(p1_side_type))
   ) u_yaw_pass (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (p0_valid),
      .in_a     (p0_a),
      .in_b     (p0_b),
      .in_ang   (p0_ang),
      .in_side  (p0_side),
      .out_valid(p1_valid),
      .out_a    (p1_len),
      .out_ang  (p1_ang),
      .out_side (p1_side)
   );

   assign p2_in_side.flags = p1_side.flags;
   assign p2_in_side.yaw   = p1_ang;

   // pitch pass over (length, y)
   gva_cordic #(
      .STAGES(CORDIC_STAGES),
      .SIDE_W($bits(p2_side_type))
   ) u_pitch_pass (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (p1_valid),
      .in_a     (p1_len),
      .in_b     (p1_unused_b),
      .in_ang   ('0),
      .in_side  (p2_in_side),
      .out_valid(p2_valid),
      .out_a    (),
      .out_ang  (p2_ang),
      .out_side (p2_side)
   );

   gva_finish u_finish (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (p2_valid),
      .in_pitch (p2_ang),
      .in_side  (p2_side),
      .out_valid(rsp_chan.valid),
      .out_yaw  (rsp_chan.yaw_angle),
      .out_pitch(rsp_chan.pitch_angle),
      .out_zero (rsp_chan.zero_vector)
   );

   assign rsp_held     = rsp_chan.valid && !rsp_chan.ready;
   assign rsp_zero_ok  = (rsp_chan.yaw_angle == YAW_ZERO_VEC) &&
                         (rsp_chan.pitch_angle == PITCH_ZERO_VEC);
   assign rsp_pitch_ok = (rsp_chan.pitch_angle >= -15'sd11520) &&
                         (rsp_chan.pitch_angle <= 15'sd11520);
   assign rsp_yaw_ok   = (rsp_chan.yaw_angle >= -17'sd11520) &&
                         (rsp_chan.yaw_angle <= 17'sd34560);
   assign pipe_valids  = {p2_valid, p1_valid, p0_valid};

`include "gaze_vector_to_angles_assert.svh"

   `GVA_ASSERT_SAME(a_zero_result, clock, reset, rsp_chan.valid && rsp_chan.zero_vector, rsp_zero_ok)
   `GVA_ASSERT_SAME(a_pitch_range, clock, reset, rsp_chan.valid, rsp_pitch_ok)
   `GVA_ASSERT_SAME(a_yaw_range, clock, reset, rsp_chan.valid, rsp_yaw_ok)
   `GVA_ASSERT_NEXT(a_stall_freeze, clock, reset, rsp_held, rsp_chan.valid && $stable(pipe_valids))

endmodule
